FILE: rtl/core/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg: shared definitions for the source text tokenizer
// Token kinds, scanner modes, character classes and the keyword table.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int MAX_WORD_CHARS = 31;
  localparam int NUMBER_BITS    = 32;
  localparam int WORD_LEN_W     = $clog2(MAX_WORD_CHARS + 1);
  localparam int WORD_ADDR_W    = $clog2(MAX_WORD_CHARS);
  localparam int KIND_W         = 5;
  localparam int TEXT_POS_W     = 5;

  // Token kinds, in table order.
  localparam logic [KIND_W-1:0] KIND_PLUS   = 5'd0;
  localparam logic [KIND_W-1:0] KIND_MINUS  = 5'd1;
  localparam logic [KIND_W-1:0] KIND_STAR   = 5'd2;
  localparam logic [KIND_W-1:0] KIND_SLASH  = 5'd3;
  localparam logic [KIND_W-1:0] KIND_ASSIGN = 5'd4;
  localparam logic [KIND_W-1:0] KIND_SEMI   = 5'd5;
  localparam logic [KIND_W-1:0] KIND_LPAREN = 5'd6;
  localparam logic [KIND_W-1:0] KIND_RPAREN = 5'd7;
  localparam logic [KIND_W-1:0] KIND_LBRACE = 5'd8;
  localparam logic [KIND_W-1:0] KIND_RBRACE = 5'd9;
  localparam logic [KIND_W-1:0] KIND_EQ     = 5'd10;
  localparam logic [KIND_W-1:0] KIND_NE     = 5'd11;
  localparam logic [KIND_W-1:0] KIND_LT     = 5'd12;
  localparam logic [KIND_W-1:0] KIND_LE     = 5'd13;
  localparam logic [KIND_W-1:0] KIND_GT     = 5'd14;
  localparam logic [KIND_W-1:0] KIND_GE     = 5'd15;
  localparam logic [KIND_W-1:0] KIND_AND    = 5'd16;
  localparam logic [KIND_W-1:0] KIND_OR     = 5'd17;
  localparam logic [KIND_W-1:0] KIND_NOT    = 5'd18;
  localparam logic [KIND_W-1:0] KIND_COMMA  = 5'd19;
  localparam logic [KIND_W-1:0] KIND_KW0    = 5'd20;
  localparam logic [KIND_W-1:0] KIND_NUMBER = 5'd24;
  localparam logic [KIND_W-1:0] KIND_IDENT  = 5'd25;
  localparam logic [KIND_W-1:0] KIND_EOF    = 5'd26;

  // Scanner mode: what the previous characters left pending.
  typedef enum logic [8:0] {
    M_IDLE   = 9'b0_0000_0001,
    M_NUMBER = 9'b0_0000_0010,
    M_WORD   = 9'b0_0000_0100,
    M_PEQ    = 9'b0_0000_1000,
    M_PBANG  = 9'b0_0001_0000,
    M_PLT    = 9'b0_0010_0000,
    M_PGT    = 9'b0_0100_0000,
    M_PAMP   = 9'b0_1000_0000,
    M_PBAR   = 9'b1_0000_0000
  } mode_t;

  // Result sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_HEAD = 4'b0010,
    ST_CHAR = 4'b0100,
    ST_TAIL = 4'b1000
  } seq_t;

  // Keyword table as byte codes, in kind order. Texts are left aligned
  // (first character in the top byte) and padded with NUL bytes.
  localparam int NUM_KEYWORDS = 4;
  localparam int KW_MAX_LEN   = 12;
  localparam int KW_IDX_W     = $clog2(KW_MAX_LEN);

  localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [NUM_KEYWORDS] = '{
    96'h7673656d5f73616c616d_0000,
    96'h7665726e695f62697374726f,
    96'h65736c69_0000000000000000,
    96'h736b6f726f5f62756475_0000
  };

  localparam logic [WORD_LEN_W-1:0] KW_LEN [NUM_KEYWORDS] = '{
    WORD_LEN_W'(10), WORD_LEN_W'(12), WORD_LEN_W'(4), WORD_LEN_W'(10)
  };

  function automatic logic [7:0] kw_byte(input int k, input logic [WORD_ADDR_W-1:0] pos);
    logic [8*KW_MAX_LEN-1:0] text;
    logic [KW_IDX_W-1:0]     idx;
    text = KW_TEXT[k];
    idx  = (int'(pos) < KW_MAX_LEN) ? KW_IDX_W'(pos) : '0;
    if (int'(pos) < KW_MAX_LEN) begin
      return text[8*(KW_MAX_LEN-1-int'(idx)) +: 8];
    end
    return 8'h00;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_letter(c) || is_digit(c) || (c == "_");
  endfunction

endpackage

FILE: rtl/core/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer: streaming lexical analyzer
// Takes one source byte per request and delivers operator, keyword, number,
// identifier and end tokens.
// ----------------------------------------------------------------------------
// One source byte (or an end marker) enters per input request, and the block
// accepts requests one at a time. A byte that causes no token does not stall
// the input. A byte that causes tokens holds the input stalled while the
// result sequencer drains them through the output register, one token per
// cycle when the output side does not stall; the stored characters of an
// identifier are replayed from the word memory at one character per cycle
// under the same condition, then a tail token follows if the byte is also a
// one-character operator or ends the source. The output register lets the
// next byte be accepted while the final token of the previous byte still
// waits downstream. Whitespace is dropped; two-character operators are found
// by holding the first character pending in the scanner mode; numbers
// saturate at all ones; words longer than the stored limit are consumed but
// truncated. Keyword detection is tracked per character as the word is
// written, so the word memory is read only to replay identifiers. The final
// result caused by each input byte carries run_last.
// ----------------------------------------------------------------------------
module source_text_tokenizer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_char,
  input  logic                                 in_end_of_source,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [stt_pkg::KIND_W-1:0]           out_token_kind,
  output logic [stt_pkg::NUMBER_BITS-1:0]      out_number_value,
  output logic [7:0]                           out_text_char,
  output logic [stt_pkg::TEXT_POS_W-1:0]       out_text_pos,
  output logic                                 out_text_last,
  output logic                                 out_run_last
);

  localparam int AW = stt_pkg::WORD_ADDR_W;
  localparam int LW = stt_pkg::WORD_LEN_W;
  localparam int NB = stt_pkg::NUMBER_BITS;
  localparam int NK = stt_pkg::NUM_KEYWORDS;
  localparam int KW = stt_pkg::KIND_W;

  // --------------------------------------------------------------------------
  // Scanner state and word memory
  // --------------------------------------------------------------------------
  stt_pkg::mode_t  mode_r, mode_nxt;
  logic [NB-1:0]   acc_r, acc_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  // One flag per keyword: the stored word still agrees with it so far.
  logic [NK-1:0]   match_r, match_nxt;

  logic [7:0]      word_mem [stt_pkg::MAX_WORD_CHARS];
  logic [7:0]      rd_data_r;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;

  // --------------------------------------------------------------------------
  // Result plan for the accepted byte: an optional head token or an
  // identifier replay, then an optional tail token.
  // --------------------------------------------------------------------------
  logic            p_head_v;
  logic [KW-1:0]   p_head_kind;
  logic [NB-1:0]   p_head_num;
  logic            p_run;
  logic            p_tail_v;
  logic [KW-1:0]   p_tail_kind;
  logic            do_flush;
  logic            do_start;
  logic            kw_hit;
  logic [KW-1:0]   kw_kind;
  logic [NB+3:0]   acc_x10;

  // Sequencer registers
  stt_pkg::seq_t   st_r, st_nxt;
  logic [KW-1:0]   head_kind_r, head_kind_nxt;
  logic [NB-1:0]   head_num_r, head_num_nxt;
  logic [LW-1:0]   run_len_r, run_len_nxt;
  logic            tail_v_r, tail_v_nxt;
  logic [KW-1:0]   tail_kind_r, tail_kind_nxt;
  logic [AW-1:0]   pos_r, pos_nxt;

  // Output register
  logic            out_valid_r;
  logic            out_free;
  logic            ld;
  logic [KW-1:0]   ld_kind;
  logic [NB-1:0]   ld_num;
  logic [7:0]      ld_char;
  logic [AW-1:0]   ld_pos;
  logic            ld_tlast;
  logic            ld_rlast;
  logic            char_last;

  logic            accept;

  assign in_stall  = (st_r != stt_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Decimal step: acc * 10 + digit, with room to see an overflow.
  assign acc_x10 = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} +
                   {{NB{1'b0}}, in_char[3:0]};

  // --------------------------------------------------------------------------
  // Scanner: next mode, accumulator, word length, keyword flags and plan.
  // --------------------------------------------------------------------------
  always_comb begin
    mode_nxt    = mode_r;
    acc_nxt     = acc_r;
    len_nxt     = len_r;
    match_nxt   = match_r;
    wr_en       = 1'b0;
    wr_addr     = len_r[AW-1:0];
    p_head_v    = 1'b0;
    p_head_kind = stt_pkg::KIND_EOF;
    p_head_num  = '0;
    p_run       = 1'b0;
    p_tail_v    = 1'b0;
    p_tail_kind = stt_pkg::KIND_EOF;
    do_flush    = 1'b0;
    do_start    = 1'b0;
    kw_hit      = 1'b0;
    kw_kind     = stt_pkg::KIND_KW0;

    if (in_end_of_source) begin
      do_flush    = 1'b1;
      p_tail_v    = 1'b1;
      p_tail_kind = stt_pkg::KIND_EOF;
    end else begin
      unique case (mode_r) inside
        stt_pkg::M_IDLE: begin
          do_start = 1'b1;
        end
        stt_pkg::M_NUMBER: begin
          if (stt_pkg::is_digit(in_char)) begin
            if (acc_x10[NB+3:NB] != 4'd0) begin
              acc_nxt = '1;
            end else begin
              acc_nxt = acc_x10[NB-1:0];
            end
          end else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        stt_pkg::M_WORD: begin
          if (stt_pkg::is_word_char(in_char)) begin
            // Characters past the storage limit are consumed and dropped.
            if (len_r < LW'(stt_pkg::MAX_WORD_CHARS)) begin
              wr_en   = 1'b1;
              len_nxt = len_r + 1'b1;
              for (int k = 0; k < NK; k++) begin
                match_nxt[k] = match_r[k] && (len_r < stt_pkg::KW_LEN[k]) &&
                               (stt_pkg::kw_byte(k, len_r[AW-1:0]) == in_char);
              end
            end
          end else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        stt_pkg::M_PEQ, stt_pkg::M_PBANG, stt_pkg::M_PLT, stt_pkg::M_PGT,
        stt_pkg::M_PAMP, stt_pkg::M_PBAR: begin
          p_head_v = 1'b1;
          if (in_char == "=" && mode_r == stt_pkg::M_PEQ) begin
            p_head_kind = stt_pkg::KIND_EQ;
          end else if (in_char == "=" && mode_r == stt_pkg::M_PBANG) begin
            p_head_kind = stt_pkg::KIND_NE;
          end else if (in_char == "=" && mode_r == stt_pkg::M_PLT) begin
            p_head_kind = stt_pkg::KIND_LE;
          end else if (in_char == "=" && mode_r == stt_pkg::M_PGT) begin
            p_head_kind = stt_pkg::KIND_GE;
          end else if (in_char == "&" && mode_r == stt_pkg::M_PAMP) begin
            p_head_kind = stt_pkg::KIND_AND;
          end else if (in_char == "|" && mode_r == stt_pkg::M_PBAR) begin
            p_head_kind = stt_pkg::KIND_OR;
          end else begin
            p_head_v = 1'b0;
            do_flush = 1'b1;
            do_start = 1'b1;
          end
          if (p_head_v) begin
            mode_nxt = stt_pkg::M_IDLE;
          end
        end
        default: begin
          mode_nxt = stt_pkg::M_IDLE;
        end
      endcase
    end

    // Close whatever the previous characters left open.
    if (do_flush) begin
      case (mode_r)
        stt_pkg::M_NUMBER: begin
          p_head_v    = 1'b1;
          p_head_kind = stt_pkg::KIND_NUMBER;
          p_head_num  = acc_r;
        end
        stt_pkg::M_WORD: begin
          for (int k = 0; k < NK; k++) begin
            if (match_r[k] && (len_r == stt_pkg::KW_LEN[k])) begin
              kw_hit  = 1'b1;
              kw_kind = stt_pkg::KIND_KW0 + KW'(k);
            end
          end
          if (kw_hit) begin
            p_head_v    = 1'b1;
            p_head_kind = kw_kind;
          end else begin
            p_run = 1'b1;
          end
        end
        stt_pkg::M_PEQ: begin
          p_head_v    = 1'b1;
          p_head_kind = stt_pkg::KIND_ASSIGN;
        end
        stt_pkg::M_PBANG: begin
          p_head_v    = 1'b1;
          p_head_kind = stt_pkg::KIND_NOT;
        end
        stt_pkg::M_PLT: begin
          p_head_v    = 1'b1;
          p_head_kind = stt_pkg::KIND_LT;
        end
        stt_pkg::M_PGT: begin
          p_head_v    = 1'b1;
          p_head_kind = stt_pkg::KIND_GT;
        end
        default: begin
          // A lone ampersand or bar is dropped.
        end
      endcase
      mode_nxt = stt_pkg::M_IDLE;
      acc_nxt  = '0;
      len_nxt  = '0;
    end

    // Begin a new token with this character.
    if (do_start) begin
      mode_nxt = stt_pkg::M_IDLE;
      case (in_char)
        "+": begin p_tail_v = 1'b1; p_tail_kind = stt_pkg::KIND_PLUS;   end
        "-": begin p_tail_v = 1'b1; p_tail_kind = stt_pkg::KIND_MINUS;  end
        "*": begin p_tail_v = 1'b1; p_tail_kind = stt_pkg::KIND_STAR;   end
        "/": begin p_tail_v = 1'b1; p_tail_kind = stt_pkg::KIND_SLASH;  end
        ";": begin p_tail_v = 1'b1; p_tail_kind = stt_pkg::KIND_SEMI;   end
        "(": begin p_tail_v = 1'b1; p_tail_kind = stt_pkg::KIND_LPAREN; end
        ")": begin p_tail_v = 1'b1; p_tail_kind = stt_pkg::KIND_RPAREN; end
        "{": begin p_tail_v = 1'b1; p_tail_kind = stt_pkg::KIND_LBRACE; end
        "}": begin p_tail_v = 1'b1; p_tail_kind = stt_pkg::KIND_RBRACE; end
        ",": begin p_tail_v = 1'b1; p_tail_kind = stt_pkg::KIND_COMMA;  end
        "=": mode_nxt = stt_pkg::M_PEQ;
        "!": mode_nxt = stt_pkg::M_PBANG;
        "<": mode_nxt = stt_pkg::M_PLT;
        ">": mode_nxt = stt_pkg::M_PGT;
        "&": mode_nxt = stt_pkg::M_PAMP;
        "|": mode_nxt = stt_pkg::M_PBAR;
        default: begin
          if (stt_pkg::is_digit(in_char)) begin
            acc_nxt  = NB'(in_char[3:0]);
            mode_nxt = stt_pkg::M_NUMBER;
          end else if (stt_pkg::is_letter(in_char)) begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            len_nxt  = LW'(1);
            mode_nxt = stt_pkg::M_WORD;
            for (int k = 0; k < NK; k++) begin
              match_nxt[k] = (stt_pkg::kw_byte(k, '0) == in_char);
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= stt_pkg::M_IDLE;
      acc_r   <= '0;
      len_r   <= '0;
      match_r <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      acc_r   <= acc_nxt;
      len_r   <= len_nxt;
      match_r <= match_nxt;
    end
  end

  // Word memory: one write port from the scanner, one registered read port
  // for identifier replay. A replay never overlaps a write.
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      word_mem[wr_addr] <= in_char;
    end
    if (rd_en) begin
      rd_data_r <= word_mem[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Result sequencer
  // --------------------------------------------------------------------------
  assign char_last = ((LW'(pos_r) + 1'b1) == run_len_r);

  always_comb begin
    st_nxt        = st_r;
    head_kind_nxt = head_kind_r;
    head_num_nxt  = head_num_r;
    run_len_nxt   = run_len_r;
    tail_v_nxt    = tail_v_r;
    tail_kind_nxt = tail_kind_r;
    pos_nxt       = pos_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    ld            = 1'b0;
    ld_kind       = stt_pkg::KIND_EOF;
    ld_num        = '0;
    ld_char       = 8'h00;
    ld_pos        = '0;
    ld_tlast      = 1'b0;
    ld_rlast      = 1'b0;

    unique case (st_r)
      stt_pkg::ST_IDLE: begin
        if (accept) begin
          head_kind_nxt = p_head_kind;
          head_num_nxt  = p_head_num;
          run_len_nxt   = len_r;
          tail_v_nxt    = p_tail_v;
          tail_kind_nxt = p_tail_kind;
          pos_nxt       = '0;
          if (p_head_v) begin
            st_nxt = stt_pkg::ST_HEAD;
          end else if (p_run) begin
            // Fetch the first stored character now.
            rd_en  = 1'b1;
            st_nxt = stt_pkg::ST_CHAR;
          end else if (p_tail_v) begin
            st_nxt = stt_pkg::ST_TAIL;
          end
        end
      end
      stt_pkg::ST_HEAD: begin
        if (out_free) begin
          ld       = 1'b1;
          ld_kind  = head_kind_r;
          ld_num   = head_num_r;
          ld_rlast = !tail_v_r;
          st_nxt   = tail_v_r ? stt_pkg::ST_TAIL : stt_pkg::ST_IDLE;
        end
      end
      stt_pkg::ST_CHAR: begin
        if (out_free) begin
          ld       = 1'b1;
          ld_kind  = stt_pkg::KIND_IDENT;
          ld_char  = rd_data_r;
          ld_pos   = pos_r;
          ld_tlast = char_last;
          ld_rlast = char_last && !tail_v_r;
          if (char_last) begin
            st_nxt = tail_v_r ? stt_pkg::ST_TAIL : stt_pkg::ST_IDLE;
          end else begin
            // The read data updates on the same edge that captures this one.
            rd_en   = 1'b1;
            rd_addr = pos_r + 1'b1;
            pos_nxt = pos_r + 1'b1;
          end
        end
      end
      stt_pkg::ST_TAIL: begin
        if (out_free) begin
          ld       = 1'b1;
          ld_kind  = tail_kind_r;
          ld_rlast = 1'b1;
          st_nxt   = stt_pkg::ST_IDLE;
        end
      end
      default: begin
        st_nxt = stt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= stt_pkg::ST_IDLE;
      tail_v_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      tail_v_r <= tail_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_kind_r <= head_kind_nxt;
    head_num_r  <= head_num_nxt;
    run_len_r   <= run_len_nxt;
    tail_kind_r <= tail_kind_nxt;
    pos_r       <= pos_nxt;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_token_kind   <= ld_kind;
      out_number_value <= ld_num;
      out_text_char    <= ld_char;
      out_text_pos     <= stt_pkg::TEXT_POS_W'(ld_pos);
      out_text_last    <= ld_tlast;
      out_run_last     <= ld_rlast;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A word in progress always holds at least one stored character.
  a_word_len : assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == stt_pkg::M_WORD) |-> (len_r != '0))
    else $error("word mode with empty word");

  // Outside word mode no stored word length lingers.
  a_len_clear : assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != stt_pkg::M_WORD) |-> (len_r == '0))
    else $error("stale word length outside word mode");

  // A delivered token that is not the last of its run leaves more to send.
  a_run_open : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !out_run_last) |-> (st_r != stt_pkg::ST_IDLE))
    else $error("run ended without a final token");

  // Only identifier characters carry the last-character flag.
  a_text_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_text_last) |-> (out_token_kind == stt_pkg::KIND_IDENT))
    else $error("text_last on a non-identifier token");

endmodule

FILE: dv/token_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// token_stream_checker: scoreboard for the source text tokenizer
// Watches both channels and keeps its own scanner model. Every accepted
// request turns into a list of expected tokens. Every accepted token is
// compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module token_stream_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [7:0]                      in_char,
  input  logic                            in_end_of_source,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [stt_pkg::KIND_W-1:0]      out_token_kind,
  input  logic [stt_pkg::NUMBER_BITS-1:0] out_number_value,
  input  logic [7:0]                      out_text_char,
  input  logic [stt_pkg::TEXT_POS_W-1:0]  out_text_pos,
  input  logic                            out_text_last,
  input  logic                            out_run_last,
  output int                              fail_count,
  output int                              tokens_pending,
  output int                              tokens_checked,
  output int                              ident_chars_checked
);

  typedef struct {
    logic [stt_pkg::KIND_W-1:0]      kind;
    logic [stt_pkg::NUMBER_BITS-1:0] value;
    logic [7:0]                      text_char;
    logic [stt_pkg::TEXT_POS_W-1:0]  text_pos;
    logic                            text_last;
    logic                            run_last;
  } token_t;

  localparam logic [63:0] NUM_SAT = (64'd1 << stt_pkg::NUMBER_BITS) - 64'd1;

  token_t                          expected_tokens [$];
  token_t                          byte_tokens [$];
  stt_pkg::mode_t                  scan_mode;
  logic [stt_pkg::NUMBER_BITS-1:0] num_acc;
  logic [7:0]                      word_mem [stt_pkg::MAX_WORD_CHARS];
  int                              word_len;

  function automatic bit is_blank(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_decimal(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  task automatic push_token(input logic [stt_pkg::KIND_W-1:0] kind,
                            input logic [stt_pkg::NUMBER_BITS-1:0] value = '0,
                            input logic [7:0] ch = 8'd0,
                            input int pos = 0,
                            input bit last = 1'b0);
    token_t t;
    t.kind      = kind;
    t.value     = value;
    t.text_char = ch;
    t.text_pos  = stt_pkg::TEXT_POS_W'(pos);
    t.text_last = last;
    t.run_last  = 1'b0;
    byte_tokens.push_back(t);
  endtask

  // A finished word is either one keyword token or a replay of its stored
  // characters. Only the stored part takes part in the keyword compare.
  task automatic close_word();
    bit hit;
    hit = 1'b0;
    for (int k = 0; k < stt_pkg::NUM_KEYWORDS; k++) begin
      if (!hit && word_len == int'(stt_pkg::KW_LEN[k])) begin
        hit = 1'b1;
        for (int i = 0; i < word_len; i++) begin
          if (word_mem[i] != stt_pkg::kw_byte(k, stt_pkg::WORD_ADDR_W'(i))) hit = 1'b0;
        end
        if (hit) push_token(stt_pkg::KIND_W'(stt_pkg::KIND_KW0 + k));
      end
    end
    if (!hit) begin
      for (int i = 0; i < word_len; i++) begin
        push_token(stt_pkg::KIND_IDENT, '0, word_mem[i], i, i == word_len - 1);
      end
    end
    word_len = 0;
  endtask

  task automatic close_pending();
    case (scan_mode)
      stt_pkg::M_NUMBER: push_token(stt_pkg::KIND_NUMBER, num_acc);
      stt_pkg::M_WORD:   close_word();
      stt_pkg::M_PEQ:    push_token(stt_pkg::KIND_ASSIGN);
      stt_pkg::M_PBANG:  push_token(stt_pkg::KIND_NOT);
      stt_pkg::M_PLT:    push_token(stt_pkg::KIND_LT);
      stt_pkg::M_PGT:    push_token(stt_pkg::KIND_GT);
      default: ;
    endcase
    scan_mode = stt_pkg::M_IDLE;
    num_acc   = '0;
    word_len  = 0;
  endtask

  task automatic open_lexeme(input logic [7:0] c);
    scan_mode = stt_pkg::M_IDLE;
    case (c)
      "+": push_token(stt_pkg::KIND_PLUS);
      "-": push_token(stt_pkg::KIND_MINUS);
      "*": push_token(stt_pkg::KIND_STAR);
      "/": push_token(stt_pkg::KIND_SLASH);
      ";": push_token(stt_pkg::KIND_SEMI);
      "(": push_token(stt_pkg::KIND_LPAREN);
      ")": push_token(stt_pkg::KIND_RPAREN);
      "{": push_token(stt_pkg::KIND_LBRACE);
      "}": push_token(stt_pkg::KIND_RBRACE);
      ",": push_token(stt_pkg::KIND_COMMA);
      "=": scan_mode = stt_pkg::M_PEQ;
      "!": scan_mode = stt_pkg::M_PBANG;
      "<": scan_mode = stt_pkg::M_PLT;
      ">": scan_mode = stt_pkg::M_PGT;
      "&": scan_mode = stt_pkg::M_PAMP;
      "|": scan_mode = stt_pkg::M_PBAR;
      default: begin
        if (is_decimal(c)) begin
          num_acc   = stt_pkg::NUMBER_BITS'(c - "0");
          scan_mode = stt_pkg::M_NUMBER;
        end else if (is_alpha(c)) begin
          word_mem[0] = c;
          word_len    = 1;
          scan_mode   = stt_pkg::M_WORD;
        end
      end
    endcase
  endtask

  task automatic tokenize_byte(input logic [7:0] c, input logic eos);
    logic [63:0] digit;
    token_t      last_tok;
    byte_tokens.delete();
    if (eos) begin
      close_pending();
      push_token(stt_pkg::KIND_EOF);
    end else begin
      case (scan_mode)
        stt_pkg::M_NUMBER: begin
          if (is_decimal(c)) begin
            digit = 64'(c - "0");
            if (64'(num_acc) > (NUM_SAT - digit) / 64'd10) begin
              num_acc = stt_pkg::NUMBER_BITS'(NUM_SAT);
            end else begin
              num_acc = stt_pkg::NUMBER_BITS'(64'(num_acc) * 64'd10 + digit);
            end
          end else begin
            close_pending();
            open_lexeme(c);
          end
        end
        stt_pkg::M_WORD: begin
          if (is_alpha(c) || is_decimal(c) || c == "_") begin
            if (word_len < stt_pkg::MAX_WORD_CHARS) begin
              word_mem[word_len] = c;
              word_len++;
            end
          end else begin
            close_pending();
            open_lexeme(c);
          end
        end
        stt_pkg::M_IDLE: open_lexeme(c);
        default: begin
          // A pending operator character either pairs with this byte or is
          // flushed on its own (a lone & or | produces nothing).
          if (c == "=" && scan_mode == stt_pkg::M_PEQ) begin
            push_token(stt_pkg::KIND_EQ);
            scan_mode = stt_pkg::M_IDLE;
          end else if (c == "=" && scan_mode == stt_pkg::M_PBANG) begin
            push_token(stt_pkg::KIND_NE);
            scan_mode = stt_pkg::M_IDLE;
          end else if (c == "=" && scan_mode == stt_pkg::M_PLT) begin
            push_token(stt_pkg::KIND_LE);
            scan_mode = stt_pkg::M_IDLE;
          end else if (c == "=" && scan_mode == stt_pkg::M_PGT) begin
            push_token(stt_pkg::KIND_GE);
            scan_mode = stt_pkg::M_IDLE;
          end else if (c == "&" && scan_mode == stt_pkg::M_PAMP) begin
            push_token(stt_pkg::KIND_AND);
            scan_mode = stt_pkg::M_IDLE;
          end else if (c == "|" && scan_mode == stt_pkg::M_PBAR) begin
            push_token(stt_pkg::KIND_OR);
            scan_mode = stt_pkg::M_IDLE;
          end else begin
            close_pending();
            open_lexeme(c);
          end
        end
      endcase
    end
    if (byte_tokens.size() > 0) begin
      last_tok          = byte_tokens.pop_back();
      last_tok.run_last = 1'b1;
      byte_tokens.push_back(last_tok);
    end
    foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
  endtask

  task automatic report_field(input string name, input logic [63:0] exp_val,
                              input logic [63:0] got_val);
    $display("%0t ns: mismatch on %s, expected %0d, actual %0d",
             $time, name, exp_val, got_val);
    fail_count++;
  endtask

  always @(posedge clk) begin
    token_t exp_tok;
    if (!rst_n) begin
      expected_tokens.delete();
      scan_mode           = stt_pkg::M_IDLE;
      num_acc             = '0;
      word_len            = 0;
      fail_count          = 0;
      tokens_checked      = 0;
      ident_chars_checked = 0;
    end else begin
      // Results are checked before the new request is modeled, so a token
      // can never be matched against expectations from its own cycle.
      if (out_valid && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          $display("%0t ns: unexpected token, expected none, actual kind %0d",
                   $time, out_token_kind);
          fail_count++;
        end else begin
          exp_tok = expected_tokens.pop_front();
          tokens_checked++;
          if (exp_tok.kind == stt_pkg::KIND_IDENT) ident_chars_checked++;
          if (out_token_kind !== exp_tok.kind)
            report_field("token_kind", exp_tok.kind, out_token_kind);
          if (out_number_value !== exp_tok.value)
            report_field("number_value", exp_tok.value, out_number_value);
          if (out_text_char !== exp_tok.text_char)
            report_field("text_char", exp_tok.text_char, out_text_char);
          if (out_text_pos !== exp_tok.text_pos)
            report_field("text_pos", exp_tok.text_pos, out_text_pos);
          if (out_text_last !== exp_tok.text_last)
            report_field("text_last", exp_tok.text_last, out_text_last);
          if (out_run_last !== exp_tok.run_last)
            report_field("run_last", exp_tok.run_last, out_run_last);
        end
      end
      if (in_valid && !in_stall) tokenize_byte(in_char, in_end_of_source);
    end
    tokens_pending = expected_tokens.size();
  end

endmodule

FILE: dv/source_text_tokenizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_tb: random source text against the tokenizer
// Sends a short directed string of operators, then random lexemes (numbers,
// words, keywords, operators, blanks, junk bytes, end markers) with random
// gaps and output back-pressure. A checker beside the block scores tokens.
// ----------------------------------------------------------------------------
module source_text_tokenizer_tb;

  // Source byte target for the random part; the run stops offering new
  // lexemes once this many requests have been accepted.
  localparam int TARGET_BYTES = 360;
  // Cycles the receiver refuses results during a long hold-off.
  localparam int LONG_HOLD    = 400;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic [7:0]                      in_char;
  logic                            in_end_of_source;
  logic                            out_valid;
  logic                            out_stall;
  logic [stt_pkg::KIND_W-1:0]      out_token_kind;
  logic [stt_pkg::NUMBER_BITS-1:0] out_number_value;
  logic [7:0]                      out_text_char;
  logic [stt_pkg::TEXT_POS_W-1:0]  out_text_pos;
  logic                            out_text_last;
  logic                            out_run_last;

  int fail_count;
  int tokens_pending;
  int tokens_checked;
  int ident_chars_checked;

  // Sender statistics, and a switch that removes the random gaps on both sides
  // for a stretch of the random part.
  int bytes_sent;
  int end_markers_sent;
  bit no_gaps;

  source_text_tokenizer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char          (in_char),
    .in_end_of_source (in_end_of_source),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_number_value (out_number_value),
    .out_text_char    (out_text_char),
    .out_text_pos     (out_text_pos),
    .out_text_last    (out_text_last),
    .out_run_last     (out_run_last)
  );

  token_stream_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_char             (in_char),
    .in_end_of_source    (in_end_of_source),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_token_kind      (out_token_kind),
    .out_number_value    (out_number_value),
    .out_text_char       (out_text_char),
    .out_text_pos        (out_text_pos),
    .out_text_last       (out_text_last),
    .out_run_last        (out_run_last),
    .fail_count          (fail_count),
    .tokens_pending      (tokens_pending),
    .tokens_checked      (tokens_checked),
    .ident_chars_checked (ident_chars_checked)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Offers one request and returns at the falling edge after it was taken.
  // Valid is only lowered when a gap follows, so back-to-back requests keep
  // it high without a glitch inside one time step.
  task automatic send_byte(input logic [7:0] c, input logic eos);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_char          <= c;
    in_end_of_source <= eos;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (eos) end_markers_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i], 1'b0);
  endtask

  // The first n characters of keyword k.
  task automatic send_keyword(input int k, input int n);
    for (int i = 0; i < n; i++) begin
      send_byte(stt_pkg::kw_byte(k, stt_pkg::WORD_ADDR_W'(i)), 1'b0);
    end
  endtask

  // Letters, digits and underscore, as allowed after the first letter.
  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  function automatic logic [7:0] letter_char();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  // One random lexeme. Most are well-formed pieces of source text; the rest
  // are blanks, junk bytes and end markers that break sequences up.
  task automatic send_lexeme();
    string singles;
    string pairs;
    int    pick;
    int    n;
    int    k;
    singles = "+-*/=;(){},<>!";
    pairs   = "==!=<=>=&&||";
    pick    = $urandom_range(0, 15);
    case (pick)
      0, 1: begin
        send_byte(singles[$urandom_range(0, singles.len() - 1)], 1'b0);
      end
      2, 3: begin
        n = 2 * $urandom_range(0, 5);
        send_byte(pairs[n], 1'b0);
        send_byte(pairs[n + 1], 1'b0);
      end
      4: begin
        // A lone ampersand or bar, followed by whatever comes next.
        send_byte($urandom_range(0, 1) ? "&" : "|", 1'b0);
      end
      5, 6: begin
        case ($urandom_range(0, 7))
          0: send_text("4294967295");
          1: send_text("4294967296");
          2: send_text("0");
          default: begin
            // Long digit runs overflow and must saturate.
            n = $urandom_range(1, 14);
            repeat (n) send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
          end
        endcase
      end
      7, 8: begin
        // Mostly short words; now and then one near or past the stored length.
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(29, 40) : $urandom_range(0, 7);
        send_byte(letter_char(), 1'b0);
        repeat (n) send_byte(word_char(), 1'b0);
      end
      9, 10: begin
        k = $urandom_range(0, 3);
        n = int'(stt_pkg::KW_LEN[k]);
        case ($urandom_range(0, 3))
          2: begin
            // Keyword followed by more word characters: an identifier.
            send_keyword(k, n);
            repeat ($urandom_range(1, 3)) send_byte(word_char(), 1'b0);
          end
          3: send_keyword(k, n - 1);
          default: send_keyword(k, n);
        endcase
      end
      11, 15: begin
        n = $urandom_range(0, 5);
        send_byte((n == 5) ? 8'd32 : 8'(9 + n), 1'b0);
      end
      12: send_byte(8'($urandom_range(0, 255)), 1'b0);
      13: begin
        case ($urandom_range(0, 3))
          0: send_byte(8'h00, 1'b0);
          1: send_byte("_", 1'b0);
          2: send_byte(8'($urandom_range(128, 255)), 1'b0);
          default: send_byte("#", 1'b0);
        endcase
      end
      default: send_byte(8'($urandom_range(0, 255)), 1'b1);
    endcase
    // Half the time a blank separates lexemes; otherwise they run together
    // and one lexeme has to end the previous one.
    if ($urandom_range(0, 1) == 0) send_byte(8'd32, 1'b0);
  endtask

  // Receiver: waits a random number of cycles before taking each token.
  // Twice in the run it holds off for a long stretch while the sender keeps
  // offering bytes, so the block backs up and stalls its input side.
  initial begin
    int hold;
    int taken;
    out_stall = 1'b0;
    taken     = 0;
    @(negedge clk);
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 6);
      if (taken == 30 || taken == 200) hold = LONG_HOLD;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    in_valid         = 1'b0;
    in_char          = 8'd0;
    in_end_of_source = 1'b0;
    rst_n            = 1'b0;
    bytes_sent       = 0;
    end_markers_sent = 0;
    no_gaps          = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Every two-character operator, then each single-character one that
    // cannot start a pair, then an end marker with nothing pending to flush.
    send_text("==!=<=>=&&||+-*/;(){},");
    send_byte(8'($urandom_range(0, 255)), 1'b1);

    while (bytes_sent < TARGET_BYTES) begin
      no_gaps = (bytes_sent >= 150 && bytes_sent < 210);
      send_lexeme();
    end
    no_gaps = 1'b0;
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    in_valid <= 1'b0;

    // Drain, then give the block time to show any stray token.
    wait (tokens_pending == 0);
    repeat (64) @(posedge clk);

    $display("Run covered %0d source bytes, %0d of them end markers.",
             bytes_sent, end_markers_sent);
    $display("Checked %0d tokens, %0d of them identifier characters.",
             tokens_checked, ident_chars_checked);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/stt_pkg.sv
rtl/core/source_text_tokenizer.sv
dv/token_stream_checker.sv
dv/source_text_tokenizer_tb.sv
